@@ design/qap_pkg.sv @@
// Package for the quantized average pooling block: payload and config types,
// register indexes, reset values and sizing constants. No dependencies.
`default_nettype none

package qap_pkg;

  // Default sizing.
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int QUEUE_DEPTH      = 4;
  localparam int PADDR_W          = 5;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_BIAS       = 3'd0;
  localparam logic [2:0] REG_SCALE_MULT = 3'd1;
  localparam logic [2:0] REG_SCALE_SHFT = 3'd2;
  localparam logic [2:0] REG_ZERO_POINT = 3'd3;
  localparam logic [2:0] REG_OUT_MIN    = 3'd4;
  localparam logic [2:0] REG_OUT_MAX    = 3'd5;
  localparam logic [2:0] REG_CH_COUNT   = 3'd6;

  // Register reset values.
  localparam logic [31:0] RST_BIAS       = 32'd0;
  localparam logic [23:0] RST_SCALE_MULT = 24'd0;
  localparam logic [5:0]  RST_SCALE_SHFT = 6'd24;
  localparam logic [7:0]  RST_ZERO_POINT = 8'd0;
  localparam logic [7:0]  RST_OUT_MIN    = 8'd0;
  localparam logic [7:0]  RST_OUT_MAX    = 8'd255;
  localparam logic [10:0] RST_CH_COUNT   = 11'd16;

  // Input transaction.
  typedef struct packed {
    logic [7:0] sample;
    logic       window_first;
    logic       window_last;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] pooled;
    logic [9:0] out_channel;
    logic       row_end;
  } out_t;

  // Configuration register set.
  typedef struct packed {
    logic [31:0] bias;
    logic [23:0] scale_multiplier;
    logic [5:0]  scale_shift;
    logic [7:0]  zero_offset;
    logic [7:0]  clamp_lo;
    logic [7:0]  clamp_hi;
    logic [10:0] channel_count;
  } cfg_t;

  // Classified item as it sits in the queue (channel travels beside it).
  typedef struct packed {
    logic [7:0] sample;
    logic       window_first;
    logic       window_last;
    logic       row_end;
  } item_t;

  // Tag that travels with a window total through requantization.
  typedef struct packed {
    logic [9:0] out_channel;
    logic       row_end;
  } res_meta_t;

endpackage

`default_nettype wire

@@ design/qap_front.sv @@
// Front end of the pooling block: accepts input transactions, tracks the
// channel counter and tags each item for the queue. Uses qap_pkg.
`default_nettype none

module qap_front #(
  parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [10:0]                     channel_count,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire qap_pkg::in_t                    in_data,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output qap_pkg::item_t                       push_item,
  output logic [$clog2(MAX_CHANNELS)-1:0]      push_ch
);

  localparam int CH_W  = $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

  logic [CH_W-1:0]  ch_r;
  logic [CH_W-1:0]  ch_nxt;
  logic [CMP_W-1:0] count_eff;
  logic [CMP_W-1:0] ch_plus1;
  logic             wrap;

  // Effective channel count: zero means one, large values saturate.
  always_comb begin
    if (channel_count == 11'd0) begin
      count_eff = CMP_W'(1);
    end else if (CMP_W'(channel_count) > CMP_W'(MAX_CHANNELS)) begin
      count_eff = CMP_W'(MAX_CHANNELS);
    end else begin
      count_eff = CMP_W'(channel_count);
    end
  end

  // The counter wraps once it reaches or passes the count.
  assign ch_plus1 = CMP_W'(ch_r) + CMP_W'(1);
  assign wrap     = (ch_plus1 >= count_eff);
  assign ch_nxt   = wrap ? '0 : CH_W'(ch_plus1);

  // Tag the item with its channel and the row end flag.
  assign in_ready                = push_ready;
  assign push_valid              = in_valid;
  assign push_ch                 = ch_r;
  assign push_item.sample        = in_data.sample;
  assign push_item.window_first  = in_data.window_first;
  assign push_item.window_last   = in_data.window_last;
  assign push_item.row_end       = wrap;

  // Channel counter advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (in_valid && push_ready) begin
      ch_r <= ch_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/qap_fifo.sv @@
// Short register queue between the front end and the back end.
// Generic width and depth; no package dependency.
`default_nettype none

module qap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_en,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/qap_accum.sv @@
// Back end, first half: per-channel accumulator memory with a
// read-modify-write pipeline and write forwarding. Uses qap_pkg.
`default_nettype none

module qap_accum #(
  parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [31:0]                 bias,
  input  wire logic                        q_valid,
  input  wire qap_pkg::item_t              q_item,
  input  wire logic [$clog2(MAX_CHANNELS)-1:0] q_ch,
  input  wire logic                        adv,
  output logic                             res_valid,
  output logic [31:0]                      res_acc,
  output qap_pkg::res_meta_t               res_meta
);

  localparam int CH_W = $clog2(MAX_CHANNELS);

  logic [31:0]        acc_mem [MAX_CHANNELS];
  logic [31:0]        rd_data_r;
  logic               b_vld_r;
  qap_pkg::item_t     b_item_r;
  logic [CH_W-1:0]    b_ch_r;
  logic               fwd_r;
  logic               fwd_nxt;
  logic [31:0]        c_acc_r;
  logic               c_vld_r;
  qap_pkg::res_meta_t c_meta_r;
  logic [31:0]        acc_base;
  logic [31:0]        acc_b;

  // The previous item writes its channel at the edge this one reads it,
  // so a matching channel takes the total straight from the next stage.
  always_comb begin
    if (b_item_r.window_first) begin
      acc_base = bias;
    end else if (fwd_r) begin
      acc_base = c_acc_r;
    end else begin
      acc_base = rd_data_r;
    end
  end

  assign acc_b   = acc_base + 32'(b_item_r.sample);
  assign fwd_nxt = b_vld_r && q_valid && (b_ch_r == q_ch);

  // Accumulator memory: one write and one registered read per cycle while adv is high.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (b_vld_r) begin
        acc_mem[b_ch_r] <= acc_b;
      end
      rd_data_r <= acc_mem[q_ch];
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r             <= q_item;
      b_ch_r               <= q_ch;
      c_acc_r              <= acc_b;
      c_meta_r.out_channel <= 10'(b_ch_r);
      c_meta_r.row_end     <= b_item_r.row_end;
    end
  end

  // Stage valids; only last elements go on to requantization.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (adv) begin
      b_vld_r <= q_valid;
      c_vld_r <= b_vld_r && b_item_r.window_last;
      fwd_r   <= fwd_nxt;
    end
  end

  assign res_valid = c_vld_r;
  assign res_acc   = c_acc_r;
  assign res_meta  = c_meta_r;

endmodule

`default_nettype wire

@@ design/qap_requant.sv @@
// Back end, second half: scales a window total, rounds, saturates, offsets
// and clamps it, and holds the result register. Uses qap_pkg.
`default_nettype none

module qap_requant (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qap_pkg::cfg_t      cfg,
  input  wire logic               res_valid,
  input  wire logic [31:0]        res_acc,
  input  wire qap_pkg::res_meta_t res_meta,
  output logic                    adv,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output qap_pkg::out_t           out_data
);

  logic               d_vld_r, e_vld_r, f_vld_r, o_vld_r;
  qap_pkg::res_meta_t d_meta_r, e_meta_r, f_meta_r;
  logic               d_neg_r, e_neg_r, f_neg_r;
  logic [31:0]        d_mag_r;
  logic [55:0]        e_prod_r;
  logic [15:0]        f_q_r;
  qap_pkg::out_t      o_data_r;

  logic [31:0]        mag_nxt;
  logic [56:0]        half;
  logic [56:0]        rsum;
  logic [56:0]        q_full;
  logic [15:0]        q_nxt;
  logic signed [17:0] s_val;
  logic signed [17:0] s_off;
  logic [7:0]         u8;
  logic [7:0]         pooled_nxt;

  // The whole back end moves when the result register is free or drained.
  assign adv = !o_vld_r || out_ready;

  // Magnitude of the signed total.
  assign mag_nxt = res_acc[31] ? (32'd0 - res_acc) : res_acc;

  // Round to nearest, ties away from zero, then limit the magnitude.
  always_comb begin
    if (cfg.scale_shift == 6'd0) begin
      half = '0;
    end else begin
      half = 57'(1) << (cfg.scale_shift - 6'd1);
    end
    rsum   = {1'b0, e_prod_r} + half;
    q_full = rsum >> cfg.scale_shift;
    q_nxt  = (q_full > 57'd32768) ? 16'h8000 : q_full[15:0];
  end

  // Restore sign, saturate to int16, add zero point and clamp.
  always_comb begin
    if (f_neg_r) begin
      s_val = 18'sd0 - $signed({2'b00, f_q_r});
    end else if (f_q_r == 16'h8000) begin
      s_val = 18'sd32767;
    end else begin
      s_val = $signed({2'b00, f_q_r});
    end
    s_off = s_val + $signed({10'd0, cfg.zero_offset});
    if (s_off < 18'sd0) begin
      u8 = 8'd0;
    end else if (s_off > 18'sd255) begin
      u8 = 8'd255;
    end else begin
      u8 = s_off[7:0];
    end
    pooled_nxt = (u8 > cfg.clamp_hi) ? cfg.clamp_hi : u8;
    if (pooled_nxt < cfg.clamp_lo) begin
      pooled_nxt = cfg.clamp_lo;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_meta_r             <= res_meta;
      d_neg_r              <= res_acc[31];
      d_mag_r              <= mag_nxt;
      e_meta_r             <= d_meta_r;
      e_neg_r              <= d_neg_r;
      e_prod_r             <= d_mag_r * 56'(cfg.scale_multiplier);
      f_meta_r             <= e_meta_r;
      f_neg_r              <= e_neg_r;
      f_q_r                <= q_nxt;
      o_data_r.pooled      <= pooled_nxt;
      o_data_r.out_channel <= f_meta_r.out_channel;
      o_data_r.row_end     <= f_meta_r.row_end;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= res_valid;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      o_vld_r <= f_vld_r;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

`default_nettype wire

@@ design/quantized_avg_pool_multipass_top.sv @@
// Top level of the quantized average pooling block: config registers,
// front end, queue and back end. Uses qap_pkg and all qap_* modules.
//
//   Channel   Ports                                  Moves
//   input     in_valid / in_ready / in_data          one sample per transaction
//   result    out_valid / out_ready / out_data       one pooled value per last element
//   config    psel penable pwrite paddr pwdata ...   32-bit register writes and reads
//
// One input transaction per cycle is sustained while the result is not stalled; the
// accumulator memory does one read and one write per cycle as the back end moves,
// with forwarding for a repeated channel. An accepted input transaction passes
// through the queue, accumulator stages b_ and c_, requantization stages d_, e_ and
// f_ and the result register before out_valid rises. Reset is synchronous; the
// accumulator memory is not cleared, and a channel holds a valid total only after
// a first element. A stalled result freezes the back end; the input side keeps
// going until the 4-entry queue is full.
`default_nettype none

module quantized_avg_pool_multipass_top #(
  parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire qap_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output qap_pkg::out_t                     out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qap_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int Q_W  = CH_W + $bits(qap_pkg::item_t);

  qap_pkg::cfg_t      cfg_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  logic               push_valid;
  logic               push_ready;
  qap_pkg::item_t     push_item;
  logic [CH_W-1:0]    push_ch;
  logic               q_valid;
  logic [Q_W-1:0]     q_data;
  qap_pkg::item_t     q_item;
  logic [CH_W-1:0]    q_ch;
  logic               adv;
  logic               res_valid;
  logic [31:0]        res_acc;
  qap_pkg::res_meta_t res_meta;

  // Register access decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias             <= qap_pkg::RST_BIAS;
      cfg_r.scale_multiplier <= qap_pkg::RST_SCALE_MULT;
      cfg_r.scale_shift      <= qap_pkg::RST_SCALE_SHFT;
      cfg_r.zero_offset      <= qap_pkg::RST_ZERO_POINT;
      cfg_r.clamp_lo         <= qap_pkg::RST_OUT_MIN;
      cfg_r.clamp_hi         <= qap_pkg::RST_OUT_MAX;
      cfg_r.channel_count    <= qap_pkg::RST_CH_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx)
        qap_pkg::REG_BIAS:       cfg_r.bias             <= pwdata;
        qap_pkg::REG_SCALE_MULT: cfg_r.scale_multiplier <= pwdata[23:0];
        qap_pkg::REG_SCALE_SHFT: cfg_r.scale_shift      <= pwdata[5:0];
        qap_pkg::REG_ZERO_POINT: cfg_r.zero_offset      <= pwdata[7:0];
        qap_pkg::REG_OUT_MIN:    cfg_r.clamp_lo         <= pwdata[7:0];
        qap_pkg::REG_OUT_MAX:    cfg_r.clamp_hi         <= pwdata[7:0];
        qap_pkg::REG_CH_COUNT:   cfg_r.channel_count    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      qap_pkg::REG_BIAS:       prdata = cfg_r.bias;
      qap_pkg::REG_SCALE_MULT: prdata = 32'(cfg_r.scale_multiplier);
      qap_pkg::REG_SCALE_SHFT: prdata = 32'(cfg_r.scale_shift);
      qap_pkg::REG_ZERO_POINT: prdata = 32'(cfg_r.zero_offset);
      qap_pkg::REG_OUT_MIN:    prdata = 32'(cfg_r.clamp_lo);
      qap_pkg::REG_OUT_MAX:    prdata = 32'(cfg_r.clamp_hi);
      qap_pkg::REG_CH_COUNT:   prdata = 32'(cfg_r.channel_count);
      default:                 prdata = 32'd0;
    endcase
  end

  qap_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_count (cfg_r.channel_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item),
    .push_ch       (push_ch)
  );

  qap_fifo #(
    .WIDTH (Q_W),
    .DEPTH (qap_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ch, push_item}),
    .pop_valid  (q_valid),
    .pop_en     (adv),
    .pop_data   (q_data)
  );

  // Split the queue head into channel and item.
  assign q_ch   = q_data[Q_W-1 -: CH_W];
  assign q_item = q_data[$bits(qap_pkg::item_t)-1:0];

  qap_accum #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .bias      (cfg_r.bias),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ch      (q_ch),
    .adv       (adv),
    .res_valid (res_valid),
    .res_acc   (res_acc),
    .res_meta  (res_meta)
  );

  qap_requant u_requant (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_acc   (res_acc),
    .res_meta  (res_meta),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/qap_checker.sv @@
// Port-level checker for the quantized average pooling top level, and the
// bind that attaches it. Uses qap_pkg.
`default_nettype none

module qap_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire qap_pkg::in_t                in_data,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire qap_pkg::out_t               out_data,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [qap_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready
);

  logic [15:0] pending_r;
  logic        in_last_acc;
  logic        out_acc;

  assign in_last_acc = in_valid && in_ready && in_data.window_last;
  assign out_acc     = out_valid && out_ready;

  // Results owed: last elements taken minus results delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_last_acc && !out_acc) begin
      pending_r <= pending_r + 16'd1;
    end else if (out_acc && !in_last_acc) begin
      pending_r <= pending_r - 16'd1;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result is shown for which no last element was taken.
  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 16'd0)
    else $error("result without a matching last element");

  // The result channel is empty in the first cycle after reset.
  a_out_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // A write to the upper clamp register reads back at once.
  a_max_rdbk: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr == {qap_pkg::REG_OUT_MAX, 2'b00}
    |=> paddr != {qap_pkg::REG_OUT_MAX, 2'b00} || prdata[7:0] == $past(pwdata[7:0]))
    else $error("upper clamp read back mismatch");

endmodule

bind quantized_avg_pool_multipass_top qap_checker u_qap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

`default_nettype wire

@@ sim/quantized_avg_pool_multipass_top_tb.sv @@
// Self-checking testbench for the quantized average pooling block.
// Depends on qap_pkg and quantized_avg_pool_multipass_top; needs nothing else.
`timescale 1ns / 100ps

module quantized_avg_pool_multipass_top_tb;

  localparam int MAX_CH       = qap_pkg::MAX_CHANNELS_DEF;
  localparam int SETTLE_CYC   = 16;    // covers the back-end pipeline plus margin
  localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction before giving up
  localparam int PHASE_ITEMS  = 20;
  localparam int PHASES       = 6;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL} fill_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  qap_pkg::in_t                 in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  qap_pkg::out_t                out_data;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [qap_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Shared between the stimulus process and the driver and monitor.
  qap_pkg::in_t   sample_q[$];
  qap_pkg::out_t  pooled_q[$];
  int             err_count = 0;
  int             quiet_cycles = 0;
  bit             steady = 1'b0;

  // Predictor state: register copy, accumulators and channel pointer.
  qap_pkg::cfg_t  shadow_cfg = '{qap_pkg::RST_BIAS, qap_pkg::RST_SCALE_MULT,
                                 qap_pkg::RST_SCALE_SHFT, qap_pkg::RST_ZERO_POINT,
                                 qap_pkg::RST_OUT_MIN, qap_pkg::RST_OUT_MAX,
                                 qap_pkg::RST_CH_COUNT};
  logic [31:0]    acc_model [MAX_CH];
  int             model_ch = 0;

  // Stimulus side: where the next item will land and which channels hold a total.
  int             gen_ch = 0;
  bit             gen_written [MAX_CH];

  quantized_avg_pool_multipass_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Zero selects one channel; anything above the memory size saturates.
  function automatic int active_count();
    int c;
    c = shadow_cfg.channel_count;
    if (c == 0) c = 1;
    if (c > MAX_CH) c = MAX_CH;
    return c;
  endfunction

  // Scale a window total down to a clamped uint8, rounding half away from zero.
  function automatic logic [7:0] requant(input logic [31:0] total);
    longint            v;
    bit                neg;
    longint unsigned   mag;
    longint unsigned   prod;
    longint unsigned   q;
    longint            s;
    int                sh;
    logic [7:0]        res;
    v = longint'($signed(total));
    neg = (v < 0);
    mag = neg ? longint'(-v) : longint'(v);
    prod = mag * longint'(shadow_cfg.scale_multiplier);
    sh = shadow_cfg.scale_shift;
    if (sh == 0) q = prod;
    else q = (prod + (64'd1 << (sh - 1))) >> sh;
    if (q > 32768) q = 32768;
    s = neg ? -longint'(q) : longint'(q);
    if (s > 32767) s = 32767;
    s = s + longint'(shadow_cfg.zero_offset);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    res = s[7:0];
    if (res > shadow_cfg.clamp_hi) res = shadow_cfg.clamp_hi;
    if (res < shadow_cfg.clamp_lo) res = shadow_cfg.clamp_lo;
    return res;
  endfunction

  // Update the accumulator for one accepted sample and queue its result, if any.
  task automatic accumulate_sample(input qap_pkg::in_t item);
    int             ch;
    int             cnt;
    logic [31:0]    acc;
    qap_pkg::out_t  res;
    ch = model_ch;
    cnt = active_count();
    if (item.window_first) acc = shadow_cfg.bias + 32'(item.sample);
    else acc = acc_model[ch] + 32'(item.sample);
    acc_model[ch] = acc;
    if (item.window_last) begin
      res.pooled = requant(acc);
      res.out_channel = ch[9:0];
      res.row_end = (ch + 1 >= cnt);
      pooled_q.push_back(res);
    end
    model_ch = (ch + 1 >= cnt) ? 0 : ch + 1;
  endtask

  task automatic check_pooled(input qap_pkg::out_t got);
    qap_pkg::out_t want;
    if (pooled_q.size() == 0) begin
      report($sformatf("result with none pending: pooled %0d channel %0d row_end %0d",
                       got.pooled, got.out_channel, got.row_end));
    end else begin
      want = pooled_q.pop_front();
      if (got.pooled !== want.pooled)
        report($sformatf("pooled got %0d expected %0d (channel %0d)",
                         got.pooled, want.pooled, want.out_channel));
      if (got.out_channel !== want.out_channel)
        report($sformatf("out_channel got %0d expected %0d",
                         got.out_channel, want.out_channel));
      if (got.row_end !== want.row_end)
        report($sformatf("row_end got %0d expected %0d (channel %0d)",
                         got.row_end, want.row_end, want.out_channel));
    end
  endtask

  // Input driver: holds a transaction until accepted, idles at random otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) accumulate_sample(in_data);
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pooled(out_data);
      out_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Count cycles in which no transaction completes on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    report($sformatf("no transaction for %0d cycles", QUIET_LIMIT));
    $display("FAIL quantized_avg_pool_multipass_top");
    $finish;
  end

  function automatic logic [31:0] reg_value(input qap_pkg::cfg_t c, input logic [2:0] idx);
    case (idx)
      qap_pkg::REG_BIAS:       return c.bias;
      qap_pkg::REG_SCALE_MULT: return 32'(c.scale_multiplier);
      qap_pkg::REG_SCALE_SHFT: return 32'(c.scale_shift);
      qap_pkg::REG_ZERO_POINT: return 32'(c.zero_offset);
      qap_pkg::REG_OUT_MIN:    return 32'(c.clamp_lo);
      qap_pkg::REG_OUT_MAX:    return 32'(c.clamp_hi);
      qap_pkg::REG_CH_COUNT:   return 32'(c.channel_count);
      default:                 return '0;
    endcase
  endfunction

  // APB write: setup cycle, then access cycle; the register takes it at the next edge.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // APB read, checked against the register copy.
  task automatic reg_check(input logic [2:0] idx);
    logic [31:0] want;
    want = reg_value(shadow_cfg, idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      report($sformatf("register %0d read 0x%08h expected 0x%08h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every queued sample is taken and every expected result is seen.
  task automatic wait_idle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pooled_q.size() != 0) @(negedge clk);
  endtask

  // Reprogram all registers with the block drained, then read them back.
  task automatic apply_config(input qap_pkg::cfg_t c);
    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    reg_write(qap_pkg::REG_BIAS, reg_value(c, qap_pkg::REG_BIAS));
    reg_write(qap_pkg::REG_SCALE_MULT, reg_value(c, qap_pkg::REG_SCALE_MULT));
    reg_write(qap_pkg::REG_SCALE_SHFT, reg_value(c, qap_pkg::REG_SCALE_SHFT));
    reg_write(qap_pkg::REG_ZERO_POINT, reg_value(c, qap_pkg::REG_ZERO_POINT));
    reg_write(qap_pkg::REG_OUT_MIN, reg_value(c, qap_pkg::REG_OUT_MIN));
    reg_write(qap_pkg::REG_OUT_MAX, reg_value(c, qap_pkg::REG_OUT_MAX));
    reg_write(qap_pkg::REG_CH_COUNT, reg_value(c, qap_pkg::REG_CH_COUNT));
    shadow_cfg = c;
    reg_check(qap_pkg::REG_BIAS);
    reg_check(qap_pkg::REG_SCALE_MULT);
    reg_check(qap_pkg::REG_SCALE_SHFT);
    reg_check(qap_pkg::REG_ZERO_POINT);
    reg_check(qap_pkg::REG_OUT_MIN);
    reg_check(qap_pkg::REG_OUT_MAX);
    reg_check(qap_pkg::REG_CH_COUNT);
    @(negedge clk);
  endtask

  function automatic qap_pkg::cfg_t make_cfg(input logic [31:0] bias, input logic [23:0] mult,
                                             input logic [5:0] shift, input logic [7:0] zp,
                                             input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [10:0] cnt);
    qap_pkg::cfg_t c;
    c.bias = bias;
    c.scale_multiplier = mult;
    c.scale_shift = shift;
    c.zero_offset = zp;
    c.clamp_lo = lo;
    c.clamp_hi = hi;
    c.channel_count = cnt;
    return c;
  endfunction

  // Mostly useful ranges, with occasional extremes and crossed clamps.
  function automatic qap_pkg::cfg_t random_cfg();
    qap_pkg::cfg_t c;
    c.bias = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(4000) - 2000);
    if ($urandom_range(7) == 0) c.scale_multiplier = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
    else c.scale_multiplier = 24'($urandom_range(24'hFFFFFF));
    if ($urandom_range(7) == 0)
      c.scale_shift = $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 55));
    else c.scale_shift = 6'($urandom_range(34, 20));
    c.zero_offset = 8'($urandom_range(255));
    c.clamp_lo = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
    c.clamp_hi = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(255, 200));
    case ($urandom_range(9)) inside
      0:       c.channel_count = 11'd0;
      [1:2]:   c.channel_count = 11'($urandom_range(64, 17));
      default: c.channel_count = 11'($urandom_range(16, 1));
    endcase
    return c;
  endfunction

  // Queue one sample; a channel with no total yet always gets a first element.
  task automatic add_item(input logic [7:0] value, input bit first, input bit last);
    qap_pkg::in_t item;
    item.sample = value;
    item.window_first = first || !gen_written[gen_ch];
    item.window_last = last;
    gen_written[gen_ch] = 1'b1;
    sample_q.push_back(item);
    gen_ch = (gen_ch + 1 >= active_count()) ? 0 : gen_ch + 1;
  endtask

  // A well-formed window: elems elements, each across every channel.
  task automatic add_window(input int elems, input fill_t fill);
    logic [7:0] value;
    for (int e = 0; e < elems; e++) begin
      for (int c = 0; c < active_count(); c++) begin
        case (fill)
          FILL_ZERO: value = 8'd0;
          FILL_FULL: value = 8'd255;
          default:   value = 8'($urandom_range(255));
        endcase
        add_item(value, e == 0, e == elems - 1);
      end
    end
  endtask

  // Samples with random window flags, which break up the element order.
  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      add_item(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  task automatic run_traffic(input int quota, input bit hold_midway);
    int    start;
    bit    held;
    fill_t fill;
    start = sample_q.size();
    held = 1'b0;
    while (sample_q.size() - start < quota) begin
      if ($urandom_range(4) == 0) begin
        add_noise($urandom_range(8, 1));
      end else begin
        case ($urandom_range(9))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_FULL;
          default: fill = FILL_RANDOM;
        endcase
        add_window($urandom_range(4, 1), fill);
      end
      // Let the sender stall until every expected result is back.
      if (hold_midway && !held && sample_q.size() - start >= quota / 2) begin
        held = 1'b1;
        wait_idle();
        start = sample_q.size() - quota / 2;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Halving with a negative bias: exact ties round away from zero.
    apply_config(make_cfg(-32'sd3, 24'd1, 6'd1, 8'd128, 8'd0, 8'd255, 11'd4));
    add_item(8'd0, 1'b1, 1'b1);
    add_item(8'd1, 1'b1, 1'b1);
    add_item(8'd2, 1'b1, 1'b1);
    add_item(8'd255, 1'b1, 1'b1);
    add_window(2, FILL_FULL);
    add_window(1, FILL_ZERO);

    // Channel count zero, accumulator wrap, and a minimum above the maximum.
    apply_config(make_cfg(32'h7FFFFFFF, 24'hFFFFFF, 6'd0, 8'd255, 8'd200, 8'd50, 11'd0));
    add_item(8'd255, 1'b1, 1'b0);
    add_item(8'd255, 1'b0, 1'b1);
    add_item(8'd0, 1'b1, 1'b1);

    // Most negative bias drives the int16 saturation low.
    apply_config(make_cfg(32'h80000000, 24'hFFFFFF, 6'd0, 8'd255, 8'd0, 8'd255, 11'd3));
    add_window(1, FILL_ZERO);
    add_item(8'd7, 1'b0, 1'b0);
    add_item(8'd9, 1'b0, 1'b1);

    // Random settings; phases end mid-row so the next count may fall below the pointer.
    for (int p = 0; p < PHASES; p++) begin
      apply_config(random_cfg());
      steady = 1'b0;
      run_traffic(PHASE_ITEMS, p == 3);
    end

    // Count beyond the memory size: one full row of 1024 single-element windows,
    // sent as one long stretch with no idling on either side.
    apply_config(make_cfg(32'd0, 24'h010000, 6'd16, 8'd0, 8'd0, 8'd255, 11'd2047));
    steady = 1'b1;
    add_window(1, FILL_RANDOM);
    add_noise(20);

    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS quantized_avg_pool_multipass_top");
    end else begin
      $display("FAIL quantized_avg_pool_multipass_top");
    end
    $finish;
  end

endmodule

@@ quantized_avg_pool_multipass_top.f @@
design/qap_pkg.sv
design/qap_front.sv
design/qap_fifo.sv
design/qap_accum.sv
design/qap_requant.sv
design/quantized_avg_pool_multipass_top.sv
design/qap_checker.sv
sim/quantized_avg_pool_multipass_top_tb.sv
